>>> rtl/fccw_pkg.sv
// Package with constants, payload types and state type of the FAT12 chain walker.
package fccw_pkg;

    localparam int FAT_BYTES         = 8192;
    localparam int SECTOR_BYTES      = 512;
    localparam int BANK_DEPTH        = (FAT_BYTES + 1) / 2;
    localparam int BANK_AW           = $clog2(BANK_DEPTH);
    localparam int IDX_W             = 13;
    localparam int CLUSTER_W         = 12;
    localparam int SECTOR_W          = 13;
    localparam int COUNT_W           = 10;
    localparam int SIZE_W            = 32;
    localparam int FIRST_DATA_SECTOR = 31;

    localparam logic [CLUSTER_W-1:0] CHAIN_END = 12'hFFF;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [1:0] STAT_LOAD_ACK = 2'd0;
    localparam logic [1:0] STAT_SECTOR   = 2'd1;
    localparam logic [1:0] STAT_NO_WALK  = 2'd2;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [IDX_W-1:0]     table_byte_index;
        logic [7:0]           table_byte;
        logic [CLUSTER_W-1:0] first_cluster;
        logic [SIZE_W-1:0]    file_size;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [SECTOR_W-1:0] sector_number;
        logic [COUNT_W-1:0]  byte_count;
        logic                last;
    } out_item_t;

    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_NEXT,
        WALK_CHECK
    } walk_state_t;

endpackage

>>> rtl/fccw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/fat12_cluster_chain_walker_unit.sv
// Top level of the FAT12 cluster chain walker with its two FAT byte banks.
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   in_item_t  (load, start, advance)
//  m_       out        m_valid / m_ready   out_item_t (status, sector, count, last)
//
// A load, an idle advance or an unused opcode needs no FAT read. A start reads one entry
// and an advance two, through the one read port of each FAT bank: an advance needs the
// entry of the current cluster and then of the next.
// Reset is synchronous on aresetn; the FAT banks are not cleared and need no clearing pass.
// A finished result waits in the output register; a walk result that finds it full holds.
module fat12_cluster_chain_walker_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fccw_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output fccw_pkg::out_item_t m_payload
);

    import fccw_pkg::*;

    walk_state_t           state_reg, state_next;
    logic [CLUSTER_W-1:0]  cluster_reg, cluster_next;
    logic [SIZE_W-1:0]     remaining_reg, remaining_next;
    logic                  walk_active_reg, walk_active_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_payload_reg, m_payload_next;
    logic                  rd_cl_odd_reg, rd_pos_odd_reg, rd_ok0_reg, rd_ok1_reg;

    logic                  out_free, accept, in_needs_read, result_load;
    logic                  rd_re;
    logic [CLUSTER_W-1:0]  rd_cluster;
    logic [IDX_W:0]        rd_sum;
    logic [IDX_W-1:0]      rd_pos, rd_pos_p1;
    logic                  we_even, we_odd;
    logic [7:0]            even_q, odd_q, b0, b1;
    logic [CLUSTER_W-1:0]  entry;
    logic [SIZE_W-1:0]     take, rem_after;
    logic                  chain_done;

    assign out_free      = !m_valid_reg || m_ready;
    assign in_needs_read = (s_payload.opcode == OP_START) ||
                           ((s_payload.opcode == OP_ADVANCE) && walk_active_reg);
    assign accept        = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            WALK_IDLE: begin
                if (accept && s_payload.opcode == OP_START) begin
                    state_next = WALK_CHECK;
                end else if (accept && in_needs_read) begin
                    state_next = WALK_NEXT;
                end
            end
            WALK_NEXT: begin
                state_next = WALK_CHECK;
            end
            WALK_CHECK: begin
                if (out_free) begin
                    state_next = WALK_IDLE;
                end
            end
            default: begin
                state_next = WALK_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        rd_re       = 1'b0;
        rd_cluster  = cluster_reg;
        result_load = 1'b0;
        unique case (state_reg)
            WALK_IDLE: begin
                s_ready     = out_free || in_needs_read;
                rd_re       = s_valid && in_needs_read;
                result_load = s_valid && !in_needs_read && out_free;
                if (s_payload.opcode == OP_START) begin
                    rd_cluster = s_payload.first_cluster;
                end
            end
            WALK_NEXT: begin
                rd_re      = 1'b1;
                rd_cluster = entry;
            end
            WALK_CHECK: begin
                result_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Entry position is floor(3c/2); the even bank always holds the byte at or after it.
    assign rd_sum    = {2'b00, rd_cluster} + {1'b0, rd_cluster, 1'b0};
    assign rd_pos    = rd_sum[IDX_W:1];
    assign rd_pos_p1 = rd_pos + 1'b1;

    assign we_even = accept && (s_payload.opcode == OP_LOAD) &&
                     (int'(s_payload.table_byte_index) < FAT_BYTES) &&
                     !s_payload.table_byte_index[0];
    assign we_odd  = accept && (s_payload.opcode == OP_LOAD) &&
                     (int'(s_payload.table_byte_index) < FAT_BYTES) &&
                     s_payload.table_byte_index[0];

    fccw_ram #(
        .WIDTH(8),
        .DEPTH(BANK_DEPTH)
    ) u_even_bank (
        .aclk  (aclk),
        .we    (we_even),
        .waddr (s_payload.table_byte_index[BANK_AW:1]),
        .wdata (s_payload.table_byte),
        .re    (rd_re),
        .raddr (rd_pos_p1[BANK_AW:1]),
        .rdata (even_q)
    );

    fccw_ram #(
        .WIDTH(8),
        .DEPTH(BANK_DEPTH)
    ) u_odd_bank (
        .aclk  (aclk),
        .we    (we_odd),
        .waddr (s_payload.table_byte_index[BANK_AW:1]),
        .wdata (s_payload.table_byte),
        .re    (rd_re),
        .raddr (rd_pos[BANK_AW:1]),
        .rdata (odd_q)
    );

    always_comb begin
        b0 = rd_pos_odd_reg ? odd_q : even_q;
        b1 = rd_pos_odd_reg ? even_q : odd_q;
        if (!rd_ok0_reg) begin
            b0 = 8'h00;
        end
        if (!rd_ok1_reg) begin
            b1 = 8'h00;
        end
        if (rd_cl_odd_reg) begin
            entry = {b1, b0[7:4]};
        end else begin
            entry = {b1[3:0], b0};
        end
    end

    assign take       = (remaining_reg > SIZE_W'(SECTOR_BYTES)) ?
                        SIZE_W'(SECTOR_BYTES) : remaining_reg;
    assign rem_after  = remaining_reg - take;
    assign chain_done = (rem_after == '0) || (entry == CHAIN_END);

    always_comb begin
        cluster_next     = cluster_reg;
        remaining_next   = remaining_reg;
        walk_active_next = walk_active_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_payload_next   = m_payload_reg;
        if (accept && s_payload.opcode == OP_START) begin
            cluster_next   = s_payload.first_cluster;
            remaining_next = s_payload.file_size;
        end
        if (state_reg == WALK_NEXT) begin
            cluster_next = entry;
        end
        if (state_reg == WALK_CHECK && out_free) begin
            remaining_next   = rem_after;
            walk_active_next = !chain_done;
        end
        if (result_load) begin
            m_valid_next = 1'b1;
            if (state_reg == WALK_CHECK) begin
                m_payload_next.status        = STAT_SECTOR;
                m_payload_next.sector_number = SECTOR_W'(FIRST_DATA_SECTOR) +
                                               {1'b0, cluster_reg};
                m_payload_next.byte_count    = take[COUNT_W-1:0];
                m_payload_next.last          = chain_done;
            end else begin
                m_payload_next.status        = (s_payload.opcode == OP_LOAD) ?
                                               STAT_LOAD_ACK : STAT_NO_WALK;
                m_payload_next.sector_number = '0;
                m_payload_next.byte_count    = '0;
                m_payload_next.last          = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= WALK_IDLE;
            cluster_reg     <= '0;
            remaining_reg   <= '0;
            walk_active_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cluster_reg     <= cluster_next;
            remaining_reg   <= remaining_next;
            walk_active_reg <= walk_active_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
        if (rd_re) begin
            rd_cl_odd_reg  <= rd_cluster[0];
            rd_pos_odd_reg <= rd_pos[0];
            rd_ok0_reg     <= int'(rd_pos) < FAT_BYTES;
            rd_ok1_reg     <= int'(rd_pos_p1) < FAT_BYTES;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef NO_ASSERTIONS
    a_load_acknowledged: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_payload.opcode == OP_LOAD |=>
            m_valid_reg && m_payload_reg.status == STAT_LOAD_ACK)
        else $error("load transaction did not produce an acknowledge");

    a_walk_flag_matches_last: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == WALK_CHECK && out_free |=>
            m_valid_reg && m_payload_reg.status == STAT_SECTOR &&
            walk_active_reg == !m_payload_reg.last)
        else $error("walk flag disagrees with the reported last mark");

    a_no_read_during_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !((we_even || we_odd) && rd_re))
        else $error("FAT bank read and write in the same cycle");
`endif

endmodule

>>> bench/chain_walk_checker.sv
// Checker that predicts every result of the FAT12 chain walker and compares it at the output.
`timescale 1ns / 100ps
module chain_walk_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  fccw_pkg::in_item_t  s_payload,
    input  logic                m_valid,
    input  logic                m_ready,
    input  fccw_pkg::out_item_t m_payload,
    output int                  mismatch_count,
    output int                  reports_outstanding
);
    import fccw_pkg::*;

    logic [7:0]           fat_copy [FAT_BYTES];
    logic [CLUSTER_W-1:0] walk_cluster;
    logic [SIZE_W-1:0]    bytes_left;
    logic                 walk_on;
    out_item_t            sector_reports_due [$];

    function automatic logic [7:0] fat_byte_at(input int unsigned idx);
        if (idx >= FAT_BYTES) return 8'h00;
        return fat_copy[idx];
    endfunction

    function automatic logic [CLUSTER_W-1:0] chain_link(input logic [CLUSTER_W-1:0] cluster);
        int unsigned pos;
        logic [7:0]  lo;
        logic [7:0]  hi;
        pos = (3 * cluster) >> 1;
        lo = fat_byte_at(pos);
        hi = fat_byte_at(pos + 1);
        if (!cluster[0]) return {hi[3:0], lo};
        return {hi, lo[7:4]};
    endfunction

    function automatic out_item_t sector_report();
        out_item_t         rep;
        logic [SIZE_W-1:0] take;
        take = (bytes_left > SECTOR_BYTES) ? SECTOR_BYTES : bytes_left;
        bytes_left = bytes_left - take;
        rep.status = STAT_SECTOR;
        rep.sector_number = SECTOR_W'(FIRST_DATA_SECTOR) + SECTOR_W'(walk_cluster);
        rep.byte_count = take[COUNT_W-1:0];
        rep.last = (bytes_left == 0) || (chain_link(walk_cluster) == CHAIN_END);
        walk_on = !rep.last;
        return rep;
    endfunction

    function automatic out_item_t walk_result(input in_item_t it);
        out_item_t rep;
        rep = '0;
        if (it.opcode == OP_LOAD) begin
            if (it.table_byte_index < FAT_BYTES) fat_copy[it.table_byte_index] = it.table_byte;
            rep.status = STAT_LOAD_ACK;
        end else if (it.opcode == OP_START) begin
            walk_cluster = it.first_cluster;
            bytes_left = it.file_size;
            rep = sector_report();
        end else if (it.opcode == OP_ADVANCE && walk_on) begin
            walk_cluster = chain_link(walk_cluster);
            rep = sector_report();
        end else begin
            rep.status = STAT_NO_WALK;
        end
        return rep;
    endfunction

    always @(posedge aclk) begin
        out_item_t due;
        bit        bad;
        if (!aresetn) begin
            sector_reports_due.delete();
            walk_cluster = '0;
            bytes_left = '0;
            walk_on = 1'b0;
            mismatch_count = 0;
            reports_outstanding <= 0;
        end else begin
            if (s_valid && s_ready) sector_reports_due.push_back(walk_result(s_payload));
            if (m_valid && m_ready) begin
                if (sector_reports_due.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, m_payload);
                    mismatch_count++;
                end else begin
                    due = sector_reports_due.pop_front();
                    bad = 1'b0;
                    if (m_payload.status !== due.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, due.status, m_payload.status);
                        bad = 1'b1;
                    end
                    if (m_payload.sector_number !== due.sector_number) begin
                        $display("%0t: sector_number expected %0d actual %0d",
                                 $time, due.sector_number, m_payload.sector_number);
                        bad = 1'b1;
                    end
                    if (m_payload.byte_count !== due.byte_count) begin
                        $display("%0t: byte_count expected %0d actual %0d",
                                 $time, due.byte_count, m_payload.byte_count);
                        bad = 1'b1;
                    end
                    if (m_payload.last !== due.last) begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, due.last, m_payload.last);
                        bad = 1'b1;
                    end
                    if (bad) mismatch_count++;
                end
            end
            reports_outstanding <= sector_reports_due.size();
        end
    end

endmodule

>>> bench/tb.sv
// Top of the FAT12 chain walker testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps
module tb;
    import fccw_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         LINKED_BYTES = 3 * (1 << CLUSTER_W) / 2;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;
    int        mismatch_count;
    int        reports_outstanding;

    bit [7:0] fat_image [FAT_BYTES];
    bit       byte_loaded [FAT_BYTES];
    bit       entry_set [1 << CLUSTER_W];
    int       linked_clusters [$];
    int       items_sent = 0;
    bit       steady_phase = 1'b0;

    always #10 aclk = ~aclk;

    fat12_cluster_chain_walker_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    chain_walk_checker scoreboard (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_payload           (s_payload),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_payload           (m_payload),
        .mismatch_count      (mismatch_count),
        .reports_outstanding (reports_outstanding)
    );

    function automatic int pick_gap();
        int r;
        if (steady_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic in_item_t rand_item();
        in_item_t    it;
        logic [31:0] r;
        r = $urandom;
        it.opcode = r[1:0];
        it.table_byte_index = r[IDX_W+1:2];
        it.table_byte = r[IDX_W+9:IDX_W+2];
        r = $urandom;
        it.first_cluster = r[CLUSTER_W-1:0];
        it.file_size = $urandom;
        return it;
    endfunction

    function automatic int pick_linked();
        return linked_clusters[$urandom_range(0, linked_clusters.size() - 1)];
    endfunction

    task automatic send_item(input in_item_t item);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_outstanding != 0) @(posedge aclk);
    endtask

    task automatic send_code(input logic [1:0] op);
        in_item_t it;
        it = rand_item();
        it.opcode = op;
        send_item(it);
    endtask

    task automatic start_walk(input int cluster, input logic [SIZE_W-1:0] size);
        in_item_t it;
        it = rand_item();
        it.opcode = OP_START;
        it.first_cluster = cluster[CLUSTER_W-1:0];
        it.file_size = size;
        send_item(it);
    endtask

    task automatic load_byte(input int idx, input logic [7:0] value);
        in_item_t it;
        it = rand_item();
        it.opcode = OP_LOAD;
        it.table_byte_index = idx[IDX_W-1:0];
        it.table_byte = value;
        fat_image[idx] = value;
        byte_loaded[idx] = 1'b1;
        send_item(it);
    endtask

    // Both bytes of an entry are rewritten; the neighbor's nibble is kept from the image.
    task automatic set_link(input int cluster, input logic [CLUSTER_W-1:0] target);
        int pos;
        pos = (3 * cluster) / 2;
        if (cluster % 2 == 0) begin
            load_byte(pos, target[7:0]);
            load_byte(pos + 1, {fat_image[pos + 1][7:4], target[11:8]});
        end else begin
            load_byte(pos, {target[3:0], fat_image[pos][3:0]});
            load_byte(pos + 1, target[11:4]);
        end
        if (!entry_set[cluster]) linked_clusters.push_back(cluster);
        entry_set[cluster] = 1'b1;
    endtask

    // Chains are built from the tail so that every written entry points at a written one.
    task automatic build_chain(input int len, output int head);
        int next;
        int node;
        next = ($urandom_range(0, 3) == 0) ? pick_linked() : CHAIN_END;
        repeat (len) begin
            node = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4095);
            set_link(node, next[CLUSTER_W-1:0]);
            next = node;
        end
        head = next;
    endtask

    task automatic noise_item();
        in_item_t it;
        int       idx;
        it = rand_item();
        case ($urandom_range(0, 3))
            0: begin
                idx = int'(it.table_byte_index);
                if (idx < LINKED_BYTES && byte_loaded[idx]) load_byte(idx, fat_image[idx]);
                else load_byte(idx, it.table_byte);
            end
            1: start_walk(pick_linked(), ($urandom_range(0, 1) == 0) ? $urandom :
                          $urandom_range(0, 3000));
            2: send_code(OP_ADVANCE);
            default: send_code(OP_UNUSED);
        endcase
    endtask

    task automatic walk_scenario();
        int          head;
        logic [31:0] size;
        if (linked_clusters.size() < 8 || $urandom_range(0, 2) == 0)
            build_chain($urandom_range(1, 6), head);
        else
            head = pick_linked();
        case ($urandom_range(0, 5))
            0: size = $urandom;
            1: size = 512 * $urandom_range(0, 6);
            2: size = $urandom_range(0, 3);
            default: size = $urandom_range(0, 3500);
        endcase
        start_walk(head, size);
        repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(0, 19) == 0) noise_item();
            else send_code(OP_ADVANCE);
        end
    endtask

    initial begin
        int hold;
        @(posedge aresetn);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6))
                @(posedge aclk);
        end
    end

    initial begin
        int r;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_code(OP_ADVANCE);
        send_code(OP_UNUSED);
        set_link(4095, CHAIN_END);
        set_link(12'hFFE, CHAIN_END);
        set_link(0, 12'hFFE);
        set_link(12'hFF0, 12'h000);
        set_link(1, 12'hFF0);
        start_walk(1, 2000);
        repeat (4) send_code(OP_ADVANCE);
        start_walk(1, 0);
        send_code(OP_ADVANCE);
        wait_for_drain();
        start_walk(12'hFF0, 32'hFFFF_FFFF);
        repeat (3) send_code(OP_ADVANCE);
        start_walk(1, 100000);
        send_code(OP_ADVANCE);
        start_walk(4095, 1);
        start_walk(4095, 32'hFFFF_FFFF);

        while (items_sent < 750) begin
            if ($urandom_range(0, 15) == 0) steady_phase = !steady_phase;
            r = $urandom_range(0, 99);
            if (r < 70) walk_scenario();
            else if (r < 97) noise_item();
            else wait_for_drain();
        end

        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
